// File: src/assert_macros.svh
// Assertion macros shared by the router ID table RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: src/lrt_pkg.sv
// Package for the LRU router ID table: sizes, codes and transfer structs.
// No dependencies.
package lrt_pkg;

    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 6;
    localparam int ADDR_W   = 64;
    localparam int OCNT_W   = 6;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_HIT      = 3'd0,
        STAT_MISS     = 3'd1,
        STAT_ADDED    = 3'd2,
        STAT_PRESENT  = 3'd3,
        STAT_REMOVED  = 3'd4,
        STAT_NOTFOUND = 3'd5,
        STAT_CLEARED  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        SLOT_NOP,
        SLOT_PROMOTE,
        SLOT_DROP,
        SLOT_INSERT,
        SLOT_CLEAR
    } slot_op_t;

    typedef struct packed {
        mode_t             mode;
        logic [ID_W-1:0]   node_id;
        logic [ADDR_W-1:0] owner_addr;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] owner_out;
        logic              evicted;
        logic [ID_W-1:0]   evicted_id;
        logic [OCNT_W-1:0] entry_count;
    } result_t;

    typedef struct packed {
        slot_op_t         op;
        logic [IDX_W-1:0] slot;
        logic [ID_W-1:0]  id;
    } slot_cmd_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
        logic             lru_found;
        logic [IDX_W-1:0] lru_idx;
        logic [ID_W-1:0]  lru_router;
    } slot_stat_t;

endpackage

// File: src/lrt_owner_ram.sv
// Owner address store: one write port, one registered read port.
// No dependencies.
module lrt_owner_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: src/lrt_slot_array.sv
// Slot tags, valid bits and recency ranks with the shared rank update unit.
// Depends on lrt_pkg.
module lrt_slot_array
    import lrt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  slot_cmd_t        cmd,
    input  logic [CNT_W-1:0] count,
    output slot_stat_t       stat
);

    logic [CAPACITY-1:0] valid_reg;
    logic [CAPACITY-1:0] valid_next;
    logic [ID_W-1:0]     router_reg  [CAPACITY];
    logic [IDX_W-1:0]    rank_reg    [CAPACITY];
    logic [IDX_W-1:0]    rank_next   [CAPACITY];
    logic [IDX_W-1:0]    sel_rank;
    logic [IDX_W-1:0]    last_rank;
    logic [CNT_W-1:0]    count_m1;

    assign count_m1  = count - CNT_W'(1);
    assign last_rank = count_m1[IDX_W-1:0];
    assign sel_rank  = rank_reg[cmd.slot];

    // tag compare, free slot and LRU search
    always_comb
    begin
        stat = '0;
        for (int i = CAPACITY - 1; i >= 0; i--)
        begin
            if (valid_reg[i] && router_reg[i] == cmd.id)
            begin
                stat.hit     = 1'b1;
                stat.hit_idx = IDX_W'(i);
            end
            if (!valid_reg[i])
            begin
                stat.free_found = 1'b1;
                stat.free_idx   = IDX_W'(i);
            end
            if (valid_reg[i] && rank_reg[i] == last_rank)
            begin
                stat.lru_found  = 1'b1;
                stat.lru_idx    = IDX_W'(i);
                stat.lru_router = router_reg[i];
            end
        end
    end

    // rank update unit
    always_comb
    begin
        valid_next = valid_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rank_next[i] = rank_reg[i];
        end
        unique case (cmd.op)
            SLOT_PROMOTE:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (valid_reg[i] && rank_reg[i] < sel_rank)
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                rank_next[cmd.slot] = '0;
            end
            SLOT_DROP:
            begin
                valid_next[cmd.slot] = 1'b0;
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (valid_reg[i] && IDX_W'(i) != cmd.slot && rank_reg[i] > sel_rank)
                    begin
                        rank_next[i] = rank_reg[i] - IDX_W'(1);
                    end
                end
            end
            SLOT_INSERT:
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
                valid_next[cmd.slot] = 1'b1;
                rank_next[cmd.slot]  = '0;
            end
            SLOT_CLEAR:
            begin
                valid_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            rank_reg[i] <= rank_next[i];
        end
        if (cmd.op == SLOT_INSERT)
        begin
            router_reg[cmd.slot] <= cmd.id;
        end
    end

endmodule

// File: src/lru_router_id_table_unit.sv
// Top level of the LRU router ID table: sequencer, count and result register.
// Depends on lrt_pkg, lrt_slot_array, lrt_owner_ram and assert_macros.svh.
//
// Usage:
//   Drive cmd and raise start; the command transfers at a rising edge with
//   start high and busy low. busy stays high until the result has been shown.
//   The result appears on result for exactly one cycle with done high; the
//   receiver cannot stall it and must take it in that cycle.
// Sequence (accept edge to done cycle): lookup, remove, clear and a refused
//   add pass through EXEC and RESP; an add through EXEC, INSERT and RESP,
//   with EVICT before INSERT when it must evict the least recently used
//   entry. A new command can transfer in the cycle after done; commands
//   do not overlap. The steps are set by the sequencer: tag compare and
//   rank update in the shared slot unit per step (exec, evict, insert),
//   plus the registered read of the owner store.
// Reset clears the valid bits, the entry count and the sequencer; no
//   clearing pass is needed.
`include "assert_macros.svh"
module lru_router_id_table_unit
    import lrt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  cmd_t    cmd,
    output logic    busy,
    output logic    done,
    output result_t result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EVICT,
        ST_INSERT,
        ST_RESP
    } state_t;

    state_t            state_reg;
    mode_t             mode_reg;
    logic [ID_W-1:0]   id_reg;
    logic [ADDR_W-1:0] owner_reg;
    logic [CNT_W-1:0]  count_reg;
    status_t           status_reg;
    logic              ev_reg;
    logic [ID_W-1:0]   ev_id_reg;
    logic              hit_rd_reg;

    slot_cmd_t         scmd;
    slot_stat_t        sstat;
    logic              ram_we;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_rdata;

    lrt_slot_array u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (scmd),
        .count (count_reg),
        .stat  (sstat)
    );

    lrt_owner_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ADDR_W)
    ) u_owner_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (sstat.free_idx),
        .wdata (owner_reg),
        .re    (ram_re),
        .raddr (sstat.hit_idx),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        scmd.op   = SLOT_NOP;
        scmd.slot = sstat.hit_idx;
        scmd.id   = id_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        unique case (state_reg)
            ST_EXEC:
            begin
                unique case (mode_reg)
                    MODE_LOOKUP:
                    begin
                        if (sstat.hit)
                        begin
                            scmd.op = SLOT_PROMOTE;
                            ram_re  = 1'b1;
                        end
                    end
                    MODE_ADD:
                    begin
                        if (sstat.hit)
                        begin
                            scmd.op = SLOT_PROMOTE;
                        end
                    end
                    MODE_REMOVE:
                    begin
                        if (sstat.hit)
                        begin
                            scmd.op = SLOT_DROP;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        scmd.op = SLOT_CLEAR;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_EVICT:
            begin
                scmd.slot = sstat.lru_idx;
                if (sstat.lru_found)
                begin
                    scmd.op = SLOT_DROP;
                end
            end
            ST_INSERT:
            begin
                scmd.slot = sstat.free_idx;
                if (sstat.free_found)
                begin
                    scmd.op = SLOT_INSERT;
                    ram_we  = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mode_reg   <= MODE_LOOKUP;
            id_reg     <= '0;
            owner_reg  <= '0;
            count_reg  <= '0;
            status_reg <= STAT_MISS;
            ev_reg     <= 1'b0;
            ev_id_reg  <= '0;
            hit_rd_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        mode_reg   <= cmd.mode;
                        id_reg     <= cmd.node_id;
                        owner_reg  <= cmd.owner_addr;
                        ev_reg     <= 1'b0;
                        ev_id_reg  <= '0;
                        hit_rd_reg <= 1'b0;
                        state_reg  <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_RESP;
                    unique case (mode_reg)
                        MODE_LOOKUP:
                        begin
                            status_reg <= sstat.hit ? STAT_HIT : STAT_MISS;
                            hit_rd_reg <= sstat.hit;
                        end
                        MODE_ADD:
                        begin
                            if (sstat.hit)
                            begin
                                status_reg <= STAT_PRESENT;
                            end
                            else if (count_reg >= CNT_W'(CAPACITY))
                            begin
                                state_reg <= ST_EVICT;
                            end
                            else
                            begin
                                state_reg <= ST_INSERT;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (sstat.hit)
                            begin
                                status_reg <= STAT_REMOVED;
                                count_reg  <= count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_reg <= STAT_NOTFOUND;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            status_reg <= STAT_CLEARED;
                            count_reg  <= '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_EVICT:
                begin
                    if (sstat.lru_found)
                    begin
                        ev_reg    <= 1'b1;
                        ev_id_reg <= sstat.lru_router;
                        count_reg <= count_reg - CNT_W'(1);
                    end
                    state_reg <= ST_INSERT;
                end
                ST_INSERT:
                begin
                    if (sstat.free_found)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                    status_reg <= STAT_ADDED;
                    state_reg  <= ST_RESP;
                end
                ST_RESP:
                begin
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    logic [OCNT_W:0] count_ext;
    assign count_ext = (OCNT_W + 1)'(count_reg);

    assign busy               = (state_reg != ST_IDLE);
    assign done               = (state_reg == ST_RESP);
    assign result.status      = status_reg;
    assign result.owner_out   = hit_rd_reg ? ram_rdata : '0;
    assign result.evicted     = ev_reg;
    assign result.evicted_id  = ev_id_reg;
    assign result.entry_count = count_ext[OCNT_W-1:0];

    `ASSERT_IMP(a_done_busy, clk, rst_n, done, busy)
    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `ASSERT_IMP(a_evict_full, clk, rst_n, state_reg == ST_EVICT,
                count_reg == CNT_W'(CAPACITY))
    `ASSERT_IMP(a_evict_added, clk, rst_n, done && result.evicted,
                result.status == STAT_ADDED)

endmodule
